### rtl/oet_pkg.sv
// shared types and constants for the oven entry and thermostat timer
`default_nettype none

package oet_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int MARGIN_W    = 7;
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_INDEX_W = 2;
    localparam int TEMP_W      = 10;
    localparam int SUM_W       = 11;
    localparam int COUNT_W     = 19;
    localparam int TEMP_BCD_W  = 12;
    localparam int TIME_BCD_W  = 16;
    localparam int VOLT_SCALE  = 500;

    localparam logic [3:0] KEY_BACK  = 4'd10;
    localparam logic [3:0] KEY_ENTER = 4'd11;

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_MARGIN     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIGHT_THRESHOLD = 2'd1;

    localparam logic [MARGIN_W-1:0]   MARGIN_RESET = 7'd5;
    localparam logic [SAMPLE_W-1:0]   LIGHT_RESET  = 10'd82;

    typedef enum logic [1:0] {
        PHASE_TEMP = 2'd0,
        PHASE_TIME = 2'd1,
        PHASE_RUN  = 2'd2
    } phase_t;

    typedef struct packed {
        logic                cmd;
        logic [3:0]          key_code;
        logic [SAMPLE_W-1:0] temp_sample;
        logic [SAMPLE_W-1:0] light_sample;
    } item_t;

    typedef struct packed {
        logic [1:0]            phase;
        logic                  heater_on;
        logic                  motor_on;
        logic                  light_on;
        logic [COUNT_W-1:0]    remaining_seconds;
        logic [TEMP_W-1:0]     setpoint;
        logic [TEMP_BCD_W-1:0] temp_entry;
        logic [TIME_BCD_W-1:0] time_entry;
        logic                  finished;
    } result_t;

endpackage

`default_nettype wire

### rtl/oet_in_stage.sv
// input register stage that holds one item ahead of the core
`default_nettype none

module oet_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire oet_pkg::item_t in_item,
    output logic                item_valid,
    output oet_pkg::item_t      item,
    input  wire logic           take
);

    logic           valid_reg;
    logic           valid_next;
    oet_pkg::item_t item_reg;
    logic           load;

    assign in_stall   = valid_reg && !take;
    assign load       = !in_stall;
    assign valid_next = load ? in_valid : 1'b1;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

### rtl/oet_core.sv
// entry, countdown and thermostat state with the result register
`default_nettype none

module oet_core #(
    parameter int ADC_BITS = 10
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write,
    input  wire logic [oet_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [oet_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire logic                                  item_valid,
    input  wire oet_pkg::item_t                        item,
    output logic                                       take,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output oet_pkg::result_t                           result
);

    localparam int ADC_MAX = (1 << ADC_BITS) - 1;
    localparam logic [oet_pkg::SAMPLE_W-1:0] SAMPLE_MASK = oet_pkg::SAMPLE_W'(ADC_MAX);
    localparam int LHS_W  = oet_pkg::SUM_W + ADC_BITS;
    localparam int RHS_W  = oet_pkg::SAMPLE_W + 9;
    localparam int PROD_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    logic [oet_pkg::MARGIN_W-1:0]   margin_reg;
    logic [oet_pkg::SAMPLE_W-1:0]   light_thr_reg;

    oet_pkg::phase_t                phase_reg, phase_next;
    logic [oet_pkg::TEMP_BCD_W-1:0] temp_digits_reg, temp_digits_next;
    logic [oet_pkg::TIME_BCD_W-1:0] time_digits_reg, time_digits_next;
    logic [oet_pkg::TEMP_W-1:0]     target_reg, target_next;
    logic [oet_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic                           heater_reg, heater_next;
    logic                           motor_reg, motor_next;
    logic                           light_reg, light_next;
    logic                           fin;

    logic                           out_valid_reg, out_valid_next;
    oet_pkg::result_t               res_reg, res_next;

    logic [oet_pkg::SAMPLE_W-1:0]   ts_m;
    logic [oet_pkg::SAMPLE_W-1:0]   ls_m;
    logic [oet_pkg::SUM_W-1:0]      temp_bin;
    logic [7:0]                     hours;
    logic [7:0]                     minutes;
    logic [19:0]                    time_secs;
    logic [oet_pkg::SUM_W-1:0]      hot_sum;
    logic [PROD_W-1:0]              lhs;
    logic [PROD_W-1:0]              rhs;
    logic [oet_pkg::COUNT_W-1:0]    count_dec;
    logic                           key_ok;

    assign take           = item_valid && !(out_valid_reg && out_stall);
    assign out_valid_next = take || (out_valid_reg && out_stall);
    assign out_valid      = out_valid_reg;
    assign result         = res_reg;

    assign ts_m = item.temp_sample & SAMPLE_MASK;
    assign ls_m = item.light_sample & SAMPLE_MASK;

    assign temp_bin = oet_pkg::SUM_W'(temp_digits_reg[11:8] * 7'd100)
                    + oet_pkg::SUM_W'(temp_digits_reg[7:4] * 4'd10)
                    + oet_pkg::SUM_W'(temp_digits_reg[3:0]);
    assign hours    = 8'(time_digits_reg[15:12] * 4'd10) + 8'(time_digits_reg[11:8]);
    assign minutes  = 8'(time_digits_reg[7:4] * 4'd10) + 8'(time_digits_reg[3:0]);
    assign time_secs = 20'(hours * 12'd3600) + 20'(minutes * 6'd60);

    assign hot_sum   = oet_pkg::SUM_W'(target_reg) + oet_pkg::SUM_W'(margin_reg);
    assign lhs       = PROD_W'(hot_sum * ADC_BITS'(ADC_MAX));
    assign rhs       = PROD_W'(ts_m * 9'(oet_pkg::VOLT_SCALE));
    assign count_dec = (count_reg != '0) ? count_reg - 1'b1 : count_reg;
    assign key_ok    = item.key_code <= oet_pkg::KEY_ENTER;

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        temp_digits_next = temp_digits_reg;
        time_digits_next = time_digits_reg;
        target_next      = target_reg;
        count_next       = count_reg;
        heater_next      = heater_reg;
        motor_next       = motor_reg;
        light_next       = light_reg;
        fin              = 1'b0;
        if (item.cmd == oet_pkg::CMD_KEY && key_ok)
        begin
            case (phase_reg)
                oet_pkg::PHASE_TIME:
                begin
                    if (item.key_code == oet_pkg::KEY_ENTER)
                    begin
                        if (hours != '0 || minutes != '0)
                        begin
                            count_next  = time_secs[oet_pkg::COUNT_W-1:0];
                            phase_next  = oet_pkg::PHASE_RUN;
                            heater_next = 1'b1;
                        end
                    end
                    else if (item.key_code == oet_pkg::KEY_BACK)
                    begin
                        time_digits_next = {4'd0, time_digits_reg[15:4]};
                    end
                    else
                    begin
                        time_digits_next = {time_digits_reg[11:0], item.key_code};
                    end
                end
                oet_pkg::PHASE_RUN:
                begin
                end
                default:
                begin
                    if (item.key_code == oet_pkg::KEY_ENTER)
                    begin
                        if (temp_bin[oet_pkg::TEMP_W-1:0] != '0)
                        begin
                            target_next = temp_bin[oet_pkg::TEMP_W-1:0];
                            phase_next  = oet_pkg::PHASE_TIME;
                        end
                    end
                    else if (item.key_code == oet_pkg::KEY_BACK)
                    begin
                        temp_digits_next = {4'd0, temp_digits_reg[11:4]};
                    end
                    else
                    begin
                        temp_digits_next = {temp_digits_reg[7:0], item.key_code};
                    end
                end
            endcase
        end
        else if (item.cmd == oet_pkg::CMD_TICK && phase_reg == oet_pkg::PHASE_RUN)
        begin
            light_next  = ls_m >= light_thr_reg;
            count_next  = count_dec;
            heater_next = lhs >= rhs;
            motor_next  = !(lhs >= rhs);
            if (count_dec == '0)
            begin
                // run over, back to temperature entry
                phase_next       = oet_pkg::PHASE_TEMP;
                temp_digits_next = '0;
                time_digits_next = '0;
                target_next      = '0;
                count_next       = '0;
                heater_next      = 1'b0;
                motor_next       = 1'b0;
                fin              = 1'b1;
            end
        end
    end

    // result
    always_comb
    begin
        res_next.phase             = phase_next;
        res_next.heater_on         = heater_next;
        res_next.motor_on          = motor_next;
        res_next.light_on          = light_next;
        res_next.remaining_seconds = count_next;
        res_next.setpoint          = target_next;
        res_next.temp_entry        = temp_digits_next;
        res_next.time_entry        = time_digits_next;
        res_next.finished          = fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg      <= oet_pkg::MARGIN_RESET;
            light_thr_reg   <= oet_pkg::LIGHT_RESET;
            phase_reg       <= oet_pkg::PHASE_TEMP;
            temp_digits_reg <= '0;
            time_digits_reg <= '0;
            target_reg      <= '0;
            count_reg       <= '0;
            heater_reg      <= 1'b0;
            motor_reg       <= 1'b0;
            light_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write && cfg_index == oet_pkg::CFG_TEMP_MARGIN)
            begin
                margin_reg <= cfg_data[oet_pkg::MARGIN_W-1:0];
            end
            if (cfg_write && cfg_index == oet_pkg::CFG_LIGHT_THRESHOLD)
            begin
                light_thr_reg <= cfg_data[oet_pkg::SAMPLE_W-1:0];
            end
            if (take)
            begin
                phase_reg       <= phase_next;
                temp_digits_reg <= temp_digits_next;
                time_digits_reg <= time_digits_next;
                target_reg      <= target_next;
                count_reg       <= count_next;
                heater_reg      <= heater_next;
                motor_reg       <= motor_next;
                light_reg       <= light_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.finished |->
            res_reg.phase == oet_pkg::PHASE_TEMP && res_reg.remaining_seconds == '0
            && !res_reg.heater_on && !res_reg.motor_on)
        else $error("finished without a cleared run");

    a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.heater_on && res_reg.motor_on))
        else $error("heater and motor both on");

    a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == oet_pkg::PHASE_RUN |-> count_reg != '0)
        else $error("run phase with zero count");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(count_reg) && $stable(phase_reg))
        else $error("state moved without a transfer");

endmodule

`default_nettype wire

### rtl/oven_entry_and_thermostat_timer.sv
// top level of the oven entry and thermostat timer
//
// input channel: in_valid/in_stall with cmd, key_code, temp_sample and
// light_sample; cmd low is a key event, cmd high a one-second tick
// output channel: out_valid/out_stall, one result per input transfer with
// phase, drive outputs, countdown, setpoint and the BCD entry registers
// configuration: cfg_write with cfg_index and cfg_data, index 0 temp_margin,
// index 1 light_threshold, taken at any clock edge with cfg_write high
// path: an input transfer passes the input register, then the state update
// and result register before the result is valid
// throughput: one item per cycle while out_stall is low
// reset: rst_n low clears all state to temperature entry, margin to 5 and
// light threshold to 82; no results are pending
// stall: while out_stall holds a result, one more item is taken into the
// input register, then in_stall rises until the result is transferred
`default_nettype none

module oven_entry_and_thermostat_timer #(
    parameter int ADC_BITS = 10
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [oet_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [oet_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            cmd,
    input  wire logic [3:0]                      key_code,
    input  wire logic [oet_pkg::SAMPLE_W-1:0]    temp_sample,
    input  wire logic [oet_pkg::SAMPLE_W-1:0]    light_sample,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [1:0]                           phase,
    output logic                                 heater_on,
    output logic                                 motor_on,
    output logic                                 light_on,
    output logic [oet_pkg::COUNT_W-1:0]          remaining_seconds,
    output logic [oet_pkg::TEMP_W-1:0]           setpoint,
    output logic [oet_pkg::TEMP_BCD_W-1:0]       temp_entry,
    output logic [oet_pkg::TIME_BCD_W-1:0]       time_entry,
    output logic                                 finished
);

    oet_pkg::item_t   in_item;
    oet_pkg::item_t   item;
    logic             item_valid;
    logic             take;
    oet_pkg::result_t result;

    assign in_item.cmd          = cmd;
    assign in_item.key_code     = key_code;
    assign in_item.temp_sample  = temp_sample;
    assign in_item.light_sample = light_sample;

    oet_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .take       (take)
    );

    oet_core #(
        .ADC_BITS (ADC_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result)
    );

    assign phase             = result.phase;
    assign heater_on         = result.heater_on;
    assign motor_on          = result.motor_on;
    assign light_on          = result.light_on;
    assign remaining_seconds = result.remaining_seconds;
    assign setpoint          = result.setpoint;
    assign temp_entry        = result.temp_entry;
    assign time_entry        = result.time_entry;
    assign finished          = result.finished;

endmodule

`default_nettype wire
